// ===== rtl/ipbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipbl_pkg;

  localparam int MAX_RANGES  = 1024;
  localparam int LINE_LENGTH = 32;

  // The range table is spread over a row of cells; entry i lives in cell
  // i modulo CELL_COUNT, at row i divided by CELL_COUNT.
  localparam int CELL_COUNT = 8;
  localparam int CELL_BITS  = $clog2(CELL_COUNT);
  localparam int ROW_DEPTH  = MAX_RANGES / CELL_COUNT;
  localparam int ROW_BITS   = $clog2(ROW_DEPTH);
  localparam int IDX_BITS   = ROW_BITS + CELL_BITS;
  localparam int COUNT_BITS = $clog2(MAX_RANGES + 1);
  localparam int POS_BITS   = $clog2(LINE_LENGTH);
  localparam int ENTRY_W    = 11;
  localparam int DRAIN_BITS = $clog2(CELL_COUNT + 1);

  localparam logic [1:0] OP_TEXT  = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  text_byte;
    logic [31:0] addr_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               banned;
    logic               line_stored;
    logic               load_error;
    logic [ENTRY_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic        line_end;
    logic        line_ok;
    logic        pos_nonzero;
    logic [31:0] low;
    logic [31:0] high;
  } parse_status_t;

  typedef struct packed {
    logic                clear;
    logic [ROW_BITS-1:0] wr_row;
    logic [31:0]         wr_low;
    logic [31:0]         wr_high;
    logic [ROW_BITS-1:0] rd_row;
    logic [31:0]         ip;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ipbl_line_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipbl_line_parser import ipbl_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic          clear,
  input  wire logic [7:0]    text_byte,
  output parse_status_t      status
);

  logic [POS_BITS-1:0] pos, pos_next;
  logic [9:0]          acc, acc_next;
  logic [31:0]         low, low_next;
  logic [31:0]         high, high_next;
  logic                line_bad, line_bad_next;

  logic [1:0]  slot;
  logic [7:0]  top_char;
  logic        digit_ok;
  logic [9:0]  acc_step;
  logic [9:0]  acc_new;

  assign slot     = pos[1:0];
  assign top_char = (slot == 2'd0) ? CHAR_TWO : CHAR_NINE;
  assign digit_ok = (text_byte >= CHAR_ZERO) && (text_byte <= top_char);
  assign acc_step = (acc << 3) + (acc << 1) + 10'(text_byte - CHAR_ZERO);
  assign acc_new  = digit_ok ? acc_step : acc;

  always_comb begin
    pos_next      = pos;
    acc_next      = acc;
    low_next      = low;
    high_next     = high;
    line_bad_next = line_bad;
    if (clear || (take && (pos == POS_BITS'(LINE_LENGTH - 1)))) begin
      pos_next      = '0;
      acc_next      = '0;
      low_next      = '0;
      high_next     = '0;
      line_bad_next = 1'b0;
    end else if (take) begin
      pos_next = pos + 1'b1;
      if (slot == 2'd3) begin
        // Position 15 separates the two addresses; the other separators are dots.
        if (text_byte != ((pos == POS_BITS'(15)) ? CHAR_DASH : CHAR_DOT)) begin
          line_bad_next = 1'b1;
        end
      end else begin
        if (!digit_ok) begin
          line_bad_next = 1'b1;
        end
        if (slot == 2'd2) begin
          if (acc_new > 10'd255) begin
            line_bad_next = 1'b1;
          end
          if (!pos[4]) begin
            low_next = {low[23:0], acc_new[7:0]};
          end else begin
            high_next = {high[23:0], acc_new[7:0]};
          end
          acc_next = '0;
        end else begin
          acc_next = acc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      acc      <= '0;
      low      <= '0;
      high     <= '0;
      line_bad <= 1'b0;
    end else begin
      pos      <= pos_next;
      acc      <= acc_next;
      low      <= low_next;
      high     <= high_next;
      line_bad <= line_bad_next;
    end
  end

  assign status.line_end    = (pos == POS_BITS'(LINE_LENGTH - 1));
  assign status.line_ok     = !line_bad && (text_byte == CHAR_NEWLINE) && (low <= high);
  assign status.pos_nonzero = (pos != '0);
  assign status.low         = low;
  assign status.high        = high;

endmodule

`default_nettype wire

// ===== rtl/ipbl_range_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipbl_range_cell import ipbl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire logic      wr_en,
  input  wire logic      rd_vld,
  input  wire logic      acc_in,
  output logic           acc_out
);

  logic [63:0] bank [ROW_DEPTH];
  logic [63:0] rd_q;
  logic        vld_q;
  logic        acc_q;
  logic        match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[cmd.wr_row] <= {cmd.wr_high, cmd.wr_low};
    end
    rd_q <= bank[cmd.rd_row];
  end

  assign match = vld_q && (cmd.ip >= rd_q[31:0]) && (cmd.ip <= rd_q[63:32]);

  // The hit flag moves one cell further along the row every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
      acc_q <= 1'b0;
    end else begin
      vld_q <= rd_vld;
      acc_q <= cmd.clear ? 1'b0 : (acc_in || match);
    end
  end

  assign acc_out = acc_q;

endmodule

`default_nettype wire

// ===== rtl/ipv4_range_blocklist_matcher_core.sv =====
// Text bytes, clears and checks that need no table walk: result in the cycle after accept,
// one item per cycle while the result side keeps up and no check sweep is running.
// A check against N stored ranges sweeps the table rows in turn across the eight range cells,
// then the hit ripples down the cell row to the result.
// Reset clears the parser, count, error and close flags; table contents stay undefined
// and need no clearing pass, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_range_blocklist_matcher_core import ipbl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]            state, state_next;
  logic [COUNT_BITS-1:0] stored_count, stored_count_next;
  logic                  error_flag, error_flag_next;
  logic                  load_closed, load_closed_next;
  logic [ROW_BITS-1:0]   row, row_next;
  logic [DRAIN_BITS-1:0] timer, timer_next;
  logic                  hit, hit_next;
  logic [31:0]           ip, ip_next;
  logic                  result_valid_next;
  out_item_t             result_next;
  logic                  res_load;
  logic                  store_now;
  logic                  cell_clear;
  logic                  err_chk;

  logic                  accept_in;
  logic                  out_free;
  parse_status_t         status;
  logic [COUNT_BITS-1:0] last_idx;
  logic [ROW_BITS-1:0]   last_row;
  logic [CELL_BITS-1:0]  wr_cell;
  cell_cmd_t             cmd;
  logic [CELL_COUNT:0]   acc_link;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE) || !out_free;
  assign accept_in  = item_valid && !item_stall;

  assign last_idx = stored_count - 1'b1;
  assign last_row = last_idx[IDX_BITS-1:CELL_BITS];
  assign wr_cell  = stored_count[CELL_BITS-1:0];

  ipbl_line_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (accept_in && (item.op == OP_TEXT) && !load_closed),
    .clear     (accept_in && (item.op == OP_CLEAR)),
    .text_byte (item.text_byte),
    .status    (status)
  );

  always_comb begin
    state_next        = state;
    stored_count_next = stored_count;
    error_flag_next   = error_flag;
    load_closed_next  = load_closed;
    row_next          = row;
    timer_next        = timer;
    hit_next          = hit || acc_link[CELL_COUNT];
    ip_next           = ip;
    res_load          = 1'b0;
    result_next       = result;
    store_now         = 1'b0;
    cell_clear        = 1'b0;
    err_chk           = error_flag || (!load_closed && status.pos_nonzero);
    result_valid_next = result_valid && result_stall;

    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          case (item.op)
            OP_TEXT: begin
              if (!load_closed && status.line_end) begin
                if (status.line_ok && (stored_count < COUNT_BITS'(MAX_RANGES))) begin
                  store_now         = 1'b1;
                  stored_count_next = stored_count + 1'b1;
                end else begin
                  error_flag_next = 1'b1;
                end
              end
              res_load                = 1'b1;
              result_next.kind        = OP_TEXT;
              result_next.banned      = 1'b0;
              result_next.line_stored = store_now;
              result_next.load_error  = error_flag_next;
              result_next.entry_count = ENTRY_W'(stored_count_next);
            end
            OP_CHECK: begin
              load_closed_next = 1'b1;
              error_flag_next  = err_chk;
              if (!err_chk && (stored_count != '0)) begin
                state_next = ST_SWEEP;
                row_next   = '0;
                cell_clear = 1'b1;
                hit_next   = 1'b0;
                ip_next    = {item.addr_word[7:0], item.addr_word[15:8],
                              item.addr_word[23:16], item.addr_word[31:24]};
              end else begin
                res_load                = 1'b1;
                result_next.kind        = OP_CHECK;
                result_next.banned      = 1'b0;
                result_next.line_stored = 1'b0;
                result_next.load_error  = err_chk;
                result_next.entry_count = ENTRY_W'(stored_count);
              end
            end
            OP_CLEAR: begin
              stored_count_next       = '0;
              error_flag_next         = 1'b0;
              load_closed_next        = 1'b0;
              res_load                = 1'b1;
              result_next.kind        = OP_CLEAR;
              result_next.banned      = 1'b0;
              result_next.line_stored = 1'b0;
              result_next.load_error  = 1'b0;
              result_next.entry_count = '0;
            end
            default: begin
              // The unused op code is taken and dropped without a result.
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (row == last_row) begin
          state_next = ST_DRAIN;
          timer_next = '0;
        end else begin
          row_next = row + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last row's hit needs the full length of the cell row to arrive.
        if (timer == DRAIN_BITS'(CELL_COUNT)) begin
          if (out_free) begin
            state_next              = ST_IDLE;
            res_load                = 1'b1;
            result_next.kind        = OP_CHECK;
            result_next.banned      = hit || acc_link[CELL_COUNT];
            result_next.line_stored = 1'b0;
            result_next.load_error  = error_flag;
            result_next.entry_count = ENTRY_W'(stored_count);
          end
        end else begin
          timer_next = timer + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (res_load) begin
      result_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_count <= '0;
      error_flag   <= 1'b0;
      load_closed  <= 1'b0;
      row          <= '0;
      timer        <= '0;
      hit          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      error_flag   <= error_flag_next;
      load_closed  <= load_closed_next;
      row          <= row_next;
      timer        <= timer_next;
      hit          <= hit_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ip     <= ip_next;
    result <= result_next;
  end

  assign cmd.clear   = cell_clear;
  assign cmd.wr_row  = stored_count[IDX_BITS-1:CELL_BITS];
  assign cmd.wr_low  = status.low;
  assign cmd.wr_high = status.high;
  assign cmd.rd_row  = row;
  assign cmd.ip      = ip;

  assign acc_link[0] = 1'b0;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    logic rd_vld;
    assign rd_vld = (state == ST_SWEEP) &&
                    (COUNT_BITS'({row, CELL_BITS'(k)}) < stored_count);
    ipbl_range_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .wr_en   (store_now && (wr_cell == CELL_BITS'(k))),
      .rd_vld  (rd_vld),
      .acc_in  (acc_link[k]),
      .acc_out (acc_link[k+1])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= COUNT_BITS'(MAX_RANGES))
    else $error("stored range count exceeds the table size");

  a_banned_only_check: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.banned) |-> (result.kind == OP_CHECK))
    else $error("banned flag set on a result that is not a check");

  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    (accept_in && (item.op == OP_CLEAR)) |=> ((stored_count == '0) && !error_flag
                                              && !load_closed))
    else $error("clear item did not reset the load state");

  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    store_now |=> (stored_count == $past(stored_count) + 1'b1) && result.line_stored)
    else $error("stored line did not advance the count");

  a_sweep_no_write: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !store_now)
    else $error("table write during a check sweep");

endmodule

`default_nettype wire
